[design/i2dt_pkg.sv]
// Shared types and constants for the signed 64-bit integer to decimal text converter.
`default_nettype none
package i2dt_pkg;

   localparam int MAG_WIDTH  = 64;
   localparam int NUM_DIGITS = 20;
   localparam int BCD_WIDTH  = 4 * NUM_DIGITS;
   localparam int CNT_WIDTH  = 6;
   localparam int LEFT_WIDTH = 5;

   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_MINUS = 8'd45;

   localparam logic [3:0] DABBLE_LIMIT = 4'd5;
   localparam logic [3:0] DABBLE_ADD   = 4'd3;

   typedef struct packed {
      logic                 neg;
      logic [MAG_WIDTH-1:0] mag;
   } job_type;

   typedef struct packed {
      logic valid;
      logic ready;
   } handshake_type;

   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_CONVERT,
      BACK_SKIP,
      BACK_SIGN,
      BACK_DIGITS
   } back_state_type;

endpackage
`default_nettype wire

[design/i2dt_front.sv]
// Front stage: accepts a value, splits it into sign and unsigned magnitude, pushes it on.
`default_nettype none
module i2dt_front
   import i2dt_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic signed [63:0]   req_value,
   output handshake_type             push_hs,
   input  wire logic                 push_ready,
   output job_type                   push_job
);

   logic    valid_ff;
   logic    valid_in;
   job_type job_ff;
   job_type job_in;
   logic    take;
   logic    push;

   assign push      = valid_ff && push_ready;
   assign req_ready = !valid_ff || push_ready;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end
      job_in.neg = req_value[63];
      job_in.mag = req_value[63] ? (~req_value + 64'd1) : req_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         job_ff <= job_in;
      end
   end

   assign push_hs.valid = valid_ff;
   assign push_hs.ready = push_ready;
   assign push_job      = job_ff;

endmodule
`default_nettype wire

[design/i2dt_queue.sv]
// Short first-in first-out queue of classified jobs between the front and back stages.
`default_nettype none
module i2dt_queue
   import i2dt_pkg::*;
#(
   parameter int DEPTH = 2
)
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire handshake_type push_hs,
   input  wire job_type       push_job,
   output logic               push_ready,
   output logic               pop_valid,
   input  wire logic          pop,
   output job_type            pop_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_hs.valid && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_job    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

[design/i2dt_back.sv]
// Back stage: bit-serial double-dabble conversion and character-by-character text output.
`default_nettype none
module i2dt_back
   import i2dt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       pop_valid,
   output logic            pop,
   input  wire job_type    pop_job,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_text_char,
   output logic            rsp_last
);

   back_state_type        state_ff;
   back_state_type        state_in;
   logic                  neg_ff;
   logic                  neg_in;
   logic [MAG_WIDTH-1:0]  mag_ff;
   logic [MAG_WIDTH-1:0]  mag_in;
   logic [BCD_WIDTH-1:0]  bcd_ff;
   logic [BCD_WIDTH-1:0]  bcd_in;
   logic [BCD_WIDTH-1:0]  bcd_adj;
   logic [CNT_WIDTH-1:0]  count_ff;
   logic [CNT_WIDTH-1:0]  count_in;
   logic [LEFT_WIDTH-1:0] left_ff;
   logic [LEFT_WIDTH-1:0] left_in;
   logic [3:0]            top_digit;
   logic                  last_digit;
   logic                  rsp_take;

   assign top_digit  = bcd_ff[BCD_WIDTH-1 -: 4];
   assign last_digit = (left_ff == LEFT_WIDTH'(1));
   assign rsp_take   = rsp_valid && rsp_ready;

   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         bcd_adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= DABBLE_LIMIT) ?
                             (bcd_ff[4*i +: 4] + DABBLE_ADD) : bcd_ff[4*i +: 4];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (pop_valid) begin
               state_in = BACK_CONVERT;
            end
         end
         BACK_CONVERT: begin
            if (count_ff == CNT_WIDTH'(MAG_WIDTH - 1)) begin
               state_in = BACK_SKIP;
            end
         end
         BACK_SKIP: begin
            if (top_digit != 4'd0 || last_digit) begin
               state_in = neg_ff ? BACK_SIGN : BACK_DIGITS;
            end
         end
         BACK_SIGN: begin
            if (rsp_ready) begin
               state_in = BACK_DIGITS;
            end
         end
         BACK_DIGITS: begin
            if (rsp_ready && last_digit) begin
               state_in = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_comb begin
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      bcd_in   = bcd_ff;
      count_in = count_ff;
      left_in  = left_ff;
      if (state_ff == BACK_IDLE) begin
         neg_in   = pop_job.neg;
         mag_in   = pop_job.mag;
         bcd_in   = '0;
         count_in = '0;
         left_in  = LEFT_WIDTH'(NUM_DIGITS);
      end else if (state_ff == BACK_CONVERT) begin
         mag_in   = {mag_ff[MAG_WIDTH-2:0], 1'b0};
         bcd_in   = {bcd_adj[BCD_WIDTH-2:0], mag_ff[MAG_WIDTH-1]};
         count_in = count_ff + CNT_WIDTH'(1);
      end else if ((state_ff == BACK_SKIP && top_digit == 4'd0 && !last_digit) ||
                   (state_ff == BACK_DIGITS && rsp_take && !last_digit)) begin
         bcd_in  = {bcd_ff[BCD_WIDTH-5:0], 4'd0};
         left_in = left_ff - LEFT_WIDTH'(1);
      end
   end

   always_comb begin
      pop           = (state_ff == BACK_IDLE) && pop_valid;
      rsp_valid     = (state_ff == BACK_SIGN) || (state_ff == BACK_DIGITS);
      rsp_text_char = (state_ff == BACK_SIGN) ? CHAR_MINUS : (CHAR_ZERO + {4'd0, top_digit});
      rsp_last      = (state_ff == BACK_DIGITS) && last_digit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff   <= neg_in;
      mag_ff   <= mag_in;
      bcd_ff   <= bcd_in;
      count_ff <= count_in;
      left_ff  <= left_in;
   end

endmodule
`default_nettype wire

[design/int64_to_decimal_text.sv]
// Top level of the signed 64-bit integer to decimal ASCII text converter.
// The req_ channel takes one signed 64-bit value per transaction on req_value.
// The rsp_ channel returns its decimal text one character per transaction,
// most significant first: an optional minus sign, then the digits with no
// leading zeros, and rsp_last marks the final character of each number.
// A front stage registers the value as sign and magnitude and hands it to a
// short queue, so new values are taken while the back stage is busy.
// The back stage converts the magnitude by double dabble, one bit per cycle.
// It then drops the leading zeros of its 20-digit result before the
// characters appear, one per cycle while rsp_ready is high. The back stage
// takes the next value from the queue only once it is idle again, after the
// last character of the current number, so the bit-serial conversion loop
// and the leading-zero scan bound the throughput.
// When the receiver stalls, the current character holds and the queue fills;
// req_ready drops once the front register and the queue are full.
// Synchronous reset empties the queue and returns the back stage to idle.
`default_nettype none
module int64_to_decimal_text
   import i2dt_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [63:0] req_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [7:0]              rsp_text_char,
   output logic                    rsp_last
);

   handshake_type push_hs;
   job_type       push_job;
   logic          push_ready;
   logic          pop_valid;
   logic          pop;
   job_type       pop_job;

   i2dt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_value  (req_value),
      .push_hs    (push_hs),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   i2dt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_hs    (push_hs),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_job    (pop_job)
   );

   i2dt_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop           (pop),
      .pop_job       (pop_job),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_text_char (rsp_text_char),
      .rsp_last      (rsp_last)
   );

endmodule
`default_nettype wire

[design/i2dt_checker.sv]
// Port-level checker for the decimal text converter and its bind to the top level.
`default_nettype none
module i2dt_checker
   import i2dt_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [7:0]  rsp_text_char,
   input wire logic        rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_text_char) && $stable(rsp_last))
      else $error("rsp transaction changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_text_char == CHAR_MINUS) ||
                    (rsp_text_char >= CHAR_ZERO && rsp_text_char <= CHAR_ZERO + 8'd9))
      else $error("rsp character is neither a minus sign nor a digit");

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_text_char == CHAR_MINUS |-> !rsp_last)
      else $error("minus sign marked as the last character");

   a_minus_then_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_text_char == CHAR_MINUS |=>
         rsp_valid && rsp_text_char != CHAR_MINUS && rsp_text_char != CHAR_ZERO)
      else $error("minus sign not followed by a nonzero leading digit");

endmodule

bind int64_to_decimal_text i2dt_checker u_i2dt_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_text_char (rsp_text_char),
   .rsp_last      (rsp_last)
);
`default_nettype wire

[tb/int64_to_decimal_text_test.sv]
// Self-checking testbench for the signed 64-bit integer to decimal ASCII text converter.
`timescale 1ns / 1ps
module int64_to_decimal_text_test
   import i2dt_pkg::*;
();

   localparam int RANDOM_VALUES  = 400;
   localparam int HOLD_AFTER     = 400;
   localparam int HOLD_CYCLES    = 1000;
   localparam int DRAIN_CYCLES   = 150;
   localparam int REPORT_LIMIT   = 10;

   typedef struct {
      logic [7:0] text_char;
      logic       last;
   } decimal_char_type;

   typedef struct {
      logic signed [63:0] value;
      string              text;
   } directed_case_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [63:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [7:0]         rsp_text_char;
   logic               rsp_last;

   decimal_char_type expected_text [$];
   int               mismatch_count = 0;
   int               chars_received = 0;
   bit               hold_done = 1'b0;

   directed_case_type directed_cases [18] = '{
      '{64'sd0, "0"},
      '{64'sd1, "1"},
      '{-64'sd1, "-1"},
      '{64'sd9, "9"},
      '{-64'sd9, "-9"},
      '{64'sd10, "10"},
      '{-64'sd10, "-10"},
      '{64'sd99, ""},
      '{64'sd100, ""},
      '{64'sd12345, ""},
      '{64'sh7FFF_FFFF_FFFF_FFFF, "9223372036854775807"},
      '{64'sh8000_0000_0000_0000, "-9223372036854775808"},
      '{64'sh8000_0000_0000_0001, "-9223372036854775807"},
      '{64'sd999999999999999999, "999999999999999999"},
      '{64'sd1000000000000000000, "1000000000000000000"},
      '{-64'sd1000000000000000000, ""},
      '{64'sh5555_5555_5555_5555, ""},
      '{64'shAAAA_AAAA_AAAA_AAAA, ""}
   };

   int64_to_decimal_text dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_text_char (rsp_text_char),
      .rsp_last      (rsp_last)
   );

   always #5 clock = ~clock;

   function automatic void predict_decimal_text(input logic signed [63:0] value);
      logic [63:0] magnitude;
      logic [3:0]  digit_stack [NUM_DIGITS];
      int          count;
      int          idx;
      magnitude = value[63] ? (64'd0 - value) : value;
      count = 0;
      do begin
         digit_stack[count] = 4'(magnitude % 64'd10);
         count++;
         magnitude = magnitude / 64'd10;
      end while (magnitude != 0);
      if (value[63]) begin
         expected_text.push_back('{CHAR_MINUS, 1'b0});
      end
      for (idx = count - 1; idx >= 0; idx--) begin
         expected_text.push_back('{CHAR_ZERO + 8'(digit_stack[idx]), idx == 0});
      end
   endfunction

   function automatic void push_typed_text(input string text);
      int idx;
      for (idx = 0; idx < text.len(); idx++) begin
         expected_text.push_back('{text[idx], idx == text.len() - 1});
      end
   endfunction

   function automatic logic signed [63:0] random_value();
      logic [63:0] bits;
      logic [63:0] power;
      int          kind;
      int          width;
      int          exponent;
      bits = {$urandom(), $urandom()};
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1, 2: begin
            return bits;
         end
         3, 4, 5: begin
            width = $urandom_range(1, 64);
            bits = bits >> (64 - width);
         end
         6, 7: begin
            exponent = $urandom_range(0, 18);
            power = 64'd1;
            repeat (exponent) power = power * 64'd10;
            bits = power + 64'($urandom_range(0, 2)) - 64'd1;
         end
         8: begin
            bits = 64'($urandom_range(0, 20));
         end
         default: begin
            bits = $urandom_range(0, 1) ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h8000_0000_0000_0000;
            return bits;
         end
      endcase
      return $urandom_range(0, 1) ? (64'd0 - bits) : bits;
   endfunction

   task automatic send_value(input logic signed [63:0] value, input string text);
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      if (text.len() == 0) begin
         predict_decimal_text(value);
      end else begin
         push_typed_text(text);
      end
      @(negedge clock);
   endtask

   task automatic pause_sender(inout int burst_left);
      int gap;
      int pick;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 7);
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
         gap = 0;
      end else if (pick < 8) begin
         gap = $urandom_range(1, 20);
      end else if (pick == 8) begin
         gap = $urandom_range(20, 110);
      end else begin
         gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   always @(posedge clock) begin
      decimal_char_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         chars_received++;
         if (expected_text.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("Unexpected transaction: text_char %0d last %0b",
                        rsp_text_char, rsp_last);
            end
         end else begin
            want = expected_text.pop_front();
            if (rsp_text_char !== want.text_char || rsp_last !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("Mismatch: expected text_char %0d last %0b, got text_char %0d last %0b",
                           want.text_char, want.last, rsp_text_char, rsp_last);
               end
            end
         end
      end
   end

   initial begin
      int segment_left;
      int mode;
      segment_left = 0;
      mode = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!hold_done && chars_received >= HOLD_AFTER) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (segment_left == 0) begin
            mode = $urandom_range(0, 2);
            segment_left = $urandom_range(20, 200);
         end
         segment_left--;
         case (mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
         @(negedge clock);
      end
   end

   initial begin
      int burst_left;
      int idx;
      burst_left = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (directed_cases[case_idx]) begin
         send_value(directed_cases[case_idx].value, directed_cases[case_idx].text);
         pause_sender(burst_left);
      end
      for (idx = 0; idx < RANDOM_VALUES; idx++) begin
         send_value(random_value(), "");
         pause_sender(burst_left);
      end
      req_valid <= 1'b0;
      while (expected_text.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_text.size() == 0) begin
         $display("PASS int64_to_decimal_text");
      end else begin
         $display("FAIL int64_to_decimal_text");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("FAIL int64_to_decimal_text");
      $finish;
   end

endmodule
